@@ design/ddbc_pkg.sv @@
package ddbc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TIME_WIDTH  = 32;

  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_WATCH  = 2'd2;
  localparam logic [1:0] CMD_CLOSE  = 2'd3;

  localparam logic [1:0] MODE_COAST = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_REV   = 2'd2;
  localparam logic [1:0] MODE_BRAKE = 2'd3;

  localparam logic [2:0] REG_DEAD_ZONE  = 3'd0;
  localparam logic [2:0] REG_STEER_PCT  = 3'd1;
  localparam logic [2:0] REG_START_DUTY = 3'd2;
  localparam logic [2:0] REG_MAX_DUTY   = 3'd3;
  localparam logic [2:0] REG_STRAIGHT   = 3'd4;
  localparam logic [2:0] REG_GAIN       = 3'd5;
  localparam logic [2:0] REG_CORR_LIM   = 3'd6;
  localparam logic [2:0] REG_TIMEOUT    = 3'd7;

  localparam logic [6:0]  RST_DEAD_ZONE  = 7'd18;
  localparam logic [6:0]  RST_STEER_PCT  = 7'd45;
  localparam logic [7:0]  RST_START_DUTY = 8'd18;
  localparam logic [7:0]  RST_MAX_DUTY   = 8'd210;
  localparam logic [7:0]  RST_STRAIGHT   = 8'd10;
  localparam logic [7:0]  RST_GAIN       = 8'd1;
  localparam logic [7:0]  RST_CORR_LIM   = 8'd20;
  localparam logic [31:0] RST_TIMEOUT    = 32'd1500;

  // floor(m/100) = (m * 20972) >> 21 for m < 2^14
  localparam logic [14:0] DIV100_MUL   = 15'd20972;
  localparam int          DIV100_SHIFT = 21;
  // floor(m/127) = (m * 66053) >> 23 for m < 2^15
  localparam logic [16:0] DIV127_MUL   = 17'd66053;
  localparam int          DIV127_SHIFT = 23;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [6:0]  dead_zone;
    logic [6:0]  steer_percent;
    logic [7:0]  start_duty;
    logic [7:0]  max_duty;
    logic [7:0]  straight_tolerance;
    logic [7:0]  balance_gain;
    logic [7:0]  correction_limit;
    logic [31:0] timeout_ticks;
  } ddbc_cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              stale;
    logic              active;
    logic              straight;
    logic              l_neg;
    logic [7:0]        l_mag;
    logic              r_neg;
    logic [7:0]        r_mag;
    logic signed [8:0] corr;
  } ddbc_item_t;

endpackage

@@ design/ddbc_front.sv @@
module ddbc_front import ddbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ddbc_cfg_t          cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [31:0]        now_time,
  input  logic [7:0]         stick_x,
  input  logic [7:0]         stick_y,
  input  logic signed [31:0] left_enc,
  input  logic signed [31:0] right_enc,
  output logic               item_valid,
  input  logic               item_ready,
  output ddbc_item_t         item
);

  localparam logic signed [COUNT_WIDTH:0] SAT_HI = (COUNT_WIDTH + 1)'(256);
  localparam logic signed [COUNT_WIDTH:0] SAT_LO = -SAT_HI;

  function automatic logic signed [7:0] axis_value(input logic [7:0] a, input logic [6:0] dz);
    logic signed [8:0] v;
    logic [7:0]        mag;
    logic signed [7:0] res;
    v   = 9'sd128 - $signed({1'b0, a});
    mag = v[8] ? 8'(-v) : v[7:0];
    if (mag <= {1'b0, dz}) res = '0;
    else if (v > 9'sd127) res = 8'sd127;
    else res = v[7:0];
    return res;
  endfunction

  function automatic logic signed [7:0] clamp127(input logic signed [9:0] v);
    logic signed [7:0] res;
    if (v > 10'sd127) res = 8'sd127;
    else if (v < -10'sd127) res = -8'sd127;
    else res = v[7:0];
    return res;
  endfunction

  function automatic logic [7:0] duty_mag(input logic [14:0] prod, input logic span_neg,
                                          input logic tzero, input logic [7:0] st_duty,
                                          input logic [7:0] mx_duty);
    logic [31:0]        full;
    logic [8:0]         q;
    logic signed [10:0] qs;
    logic signed [10:0] d;
    logic [7:0]         res;
    full = 32'(prod) * 32'(DIV127_MUL);
    q    = full[DIV127_SHIFT +: 9];
    qs   = $signed({2'b0, q});
    d    = $signed({3'b0, st_duty}) + (span_neg ? -qs : qs);
    if (tzero) res = '0;
    else if (d < 11'sd0) res = '0;
    else if (d > $signed({3'b0, mx_duty})) res = mx_duty;
    else res = d[7:0];
    return res;
  endfunction

  logic en, accept;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  logic [COUNT_WIDTH-1:0] prev_l, prev_r;
  logic [TIME_WIDTH-1:0]  last_rt;
  logic signed [7:0]      tgt_l, tgt_r;
  logic                   tgt_on;

  // stage 1
  logic [1:0]             s1_cmd;
  logic                   s1_stale, s1_ax_neg;
  logic signed [7:0]      s1_thr;
  logic [13:0]            s1_st_prod;
  logic [COUNT_WIDTH-1:0] s1_ld, s1_rd;
  // stage 2
  logic [1:0]             s2_cmd;
  logic                   s2_stale;
  logic signed [7:0]      s2_lt, s2_rt;
  logic signed [9:0]      s2_dsat;
  // stage 3
  logic [1:0]             s3_cmd;
  logic                   s3_stale, s3_span_neg, s3_l_neg, s3_r_neg, s3_l_zero, s3_r_zero;
  logic                   s3_straight, s3_active;
  logic [14:0]            s3_l_prod, s3_r_prod;
  logic signed [17:0]     s3_corr_prod;
  // stage 4
  ddbc_item_t             s4_item;

  // stage 1 logic
  logic signed [7:0]      ax_d, thr_d;
  logic [6:0]             ax_mag_d;
  logic [13:0]            st_prod_d;
  logic [TIME_WIDTH-1:0]  elapsed_d;
  logic                   stale_d;

  assign en       = !s4_valid || item_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;

  assign ax_d      = axis_value(stick_x, cfg.dead_zone);
  assign thr_d     = axis_value(stick_y, cfg.dead_zone);
  assign ax_mag_d  = 7'(ax_d[7] ? -ax_d : ax_d);
  assign st_prod_d = 14'(ax_mag_d) * 14'(cfg.steer_percent);
  assign elapsed_d = now_time[TIME_WIDTH-1:0] - last_rt;
  assign stale_d   = 32'(elapsed_d) > cfg.timeout_ticks;

  // stage 2 logic
  logic [28:0]            st_full;
  logic [7:0]             st_q;
  logic signed [8:0]      st_s;
  logic signed [7:0]      mix_l, mix_r;
  logic [COUNT_WIDTH-1:0] la, ra;
  logic signed [COUNT_WIDTH:0] ddiff;
  logic signed [9:0]      dsat_d;

  assign st_full = 29'(s1_st_prod) * 29'(DIV100_MUL);
  assign st_q    = st_full[DIV100_SHIFT +: 8];
  assign st_s    = s1_ax_neg ? -$signed({1'b0, st_q}) : $signed({1'b0, st_q});
  assign mix_l   = clamp127(10'(s1_thr) + 10'(st_s));
  assign mix_r   = clamp127(10'(s1_thr) - 10'(st_s));
  assign tgt_on  = (tgt_l != 8'sd0) || (tgt_r != 8'sd0);
  assign la      = s1_ld[COUNT_WIDTH-1] ? -s1_ld : s1_ld;
  assign ra      = s1_rd[COUNT_WIDTH-1] ? -s1_rd : s1_rd;
  assign ddiff   = $signed({1'b0, la}) - $signed({1'b0, ra});
  assign dsat_d  = (ddiff > SAT_HI) ? 10'sd256 :
                   (ddiff < SAT_LO) ? -10'sd256 : ddiff[9:0];

  // stage 3 logic
  logic signed [8:0] span, tdiff;
  logic [7:0]        span_mag;
  logic [8:0]        tdiff_mag;
  logic [6:0]        lt_mag, rt_mag;

  assign span      = $signed({1'b0, cfg.max_duty}) - $signed({1'b0, cfg.start_duty});
  assign span_mag  = 8'(span[8] ? -span : span);
  assign lt_mag    = 7'(s2_lt[7] ? -s2_lt : s2_lt);
  assign rt_mag    = 7'(s2_rt[7] ? -s2_rt : s2_rt);
  assign tdiff     = 9'(s2_lt) - 9'(s2_rt);
  assign tdiff_mag = tdiff[8] ? 9'(-tdiff) : 9'(tdiff);

  // stage 4 logic
  logic signed [17:0] lim;
  logic signed [8:0]  corr_d;

  assign lim    = $signed({10'b0, cfg.correction_limit});
  assign corr_d = (s3_corr_prod > lim) ? lim[8:0] :
                  (s3_corr_prod < -lim) ? 9'(-lim) : s3_corr_prod[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      prev_l   <= '0;
      prev_r   <= '0;
      last_rt  <= '0;
      tgt_l    <= '0;
      tgt_r    <= '0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      if (accept && command == CMD_TICK) begin
        prev_l <= left_enc[COUNT_WIDTH-1:0];
        prev_r <= right_enc[COUNT_WIDTH-1:0];
      end
      if (accept && command == CMD_REPORT) begin
        last_rt <= now_time[TIME_WIDTH-1:0];
      end
      // targets follow transactions in order as they leave stage 1
      if (s1_valid) begin
        unique case (s1_cmd)
          CMD_REPORT: begin
            tgt_l <= mix_l;
            tgt_r <= mix_r;
          end
          CMD_TICK: begin
          end
          CMD_WATCH: begin
            if (tgt_on && s1_stale) begin
              tgt_l <= '0;
              tgt_r <= '0;
            end
          end
          CMD_CLOSE: begin
            tgt_l <= '0;
            tgt_r <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd     <= command;
      s1_stale   <= stale_d;
      s1_thr     <= thr_d;
      s1_ax_neg  <= ax_d[7];
      s1_st_prod <= st_prod_d;
      s1_ld      <= left_enc[COUNT_WIDTH-1:0] - prev_l;
      s1_rd      <= right_enc[COUNT_WIDTH-1:0] - prev_r;

      s2_cmd     <= s1_cmd;
      s2_stale   <= s1_stale;
      s2_lt      <= (s1_cmd == CMD_TICK) ? tgt_l : mix_l;
      s2_rt      <= (s1_cmd == CMD_TICK) ? tgt_r : mix_r;
      s2_dsat    <= dsat_d;

      s3_cmd       <= s2_cmd;
      s3_stale     <= s2_stale;
      s3_span_neg  <= span[8];
      s3_l_prod    <= 15'(lt_mag) * 15'(span_mag);
      s3_r_prod    <= 15'(rt_mag) * 15'(span_mag);
      s3_l_neg     <= s2_lt[7];
      s3_r_neg     <= s2_rt[7];
      s3_l_zero    <= (s2_lt == 8'sd0);
      s3_r_zero    <= (s2_rt == 8'sd0);
      s3_active    <= (s2_lt != 8'sd0) || (s2_rt != 8'sd0);
      s3_straight  <= (s2_lt != 8'sd0) && (s2_rt != 8'sd0) && (s2_lt[7] == s2_rt[7]) &&
                      (tdiff_mag <= {1'b0, cfg.straight_tolerance});
      s3_corr_prod <= 18'(s2_dsat) * $signed({10'b0, cfg.balance_gain});

      s4_item.cmd      <= s3_cmd;
      s4_item.stale    <= s3_stale;
      s4_item.active   <= s3_active;
      s4_item.straight <= s3_straight;
      s4_item.l_neg    <= s3_l_neg;
      s4_item.l_mag    <= duty_mag(s3_l_prod, s3_span_neg, s3_l_zero,
                                   cfg.start_duty, cfg.max_duty);
      s4_item.r_neg    <= s3_r_neg;
      s4_item.r_mag    <= duty_mag(s3_r_prod, s3_span_neg, s3_r_zero,
                                   cfg.start_duty, cfg.max_duty);
      s4_item.corr     <= corr_d;
    end
  end

  assign item_valid = s4_valid;
  assign item       = s4_item;

endmodule

@@ design/ddbc_queue.sv @@
module ddbc_queue import ddbc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ddbc_item_t din,
  input  logic       pop,
  output ddbc_item_t dout,
  output logic       full,
  output logic       empty
);

  ddbc_item_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;

  assign full  = (count == (Q_AW + 1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW + 1)'(Q_DEPTH))
    else $error("queue count out of range");

endmodule

@@ design/ddbc_back.sv @@
module ddbc_back import ddbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ddbc_item_t        item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        left_mode,
  output logic [7:0]        left_duty,
  output logic [1:0]        right_mode,
  output logic [7:0]        right_duty,
  output logic              running,
  output logic signed [8:0] correction
);

  function automatic logic [7:0] clamp255(input logic signed [9:0] v);
    logic [7:0] res;
    if (v < 10'sd0) res = '0;
    else if (v > 10'sd255) res = 8'hFF;
    else res = v[7:0];
    return res;
  endfunction

  logic pop;

  logic signed [8:0] corr_eff;
  logic signed [9:0] l_adj, r_adj;
  logic [7:0]        lm, rm;
  logic              l_zero, r_zero;

  assign item_ready = !out_valid || out_ready;
  assign pop        = item_valid && item_ready;

  assign corr_eff = item.straight ? item.corr : 9'sd0;
  assign l_adj    = $signed({2'b0, item.l_mag}) - 10'(corr_eff);
  assign r_adj    = $signed({2'b0, item.r_mag}) + 10'(corr_eff);
  assign lm       = clamp255(l_adj);
  assign rm       = clamp255(r_adj);
  assign l_zero   = (item.l_mag == 8'd0) || (lm == 8'd0);
  assign r_zero   = (item.r_mag == 8'd0) || (rm == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      left_mode  <= MODE_COAST;
      left_duty  <= '0;
      right_mode <= MODE_COAST;
      right_duty <= '0;
      running    <= 1'b0;
      correction <= '0;
    end else begin
      if (pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (pop) begin
        unique case (item.cmd)
          CMD_REPORT: begin
            if (item.active) begin
              running <= 1'b1;
            end else begin
              left_mode  <= MODE_COAST;
              left_duty  <= '0;
              right_mode <= MODE_COAST;
              right_duty <= '0;
              running    <= 1'b0;
            end
          end
          CMD_TICK: begin
            if (!item.active) begin
              left_mode  <= MODE_COAST;
              left_duty  <= '0;
              right_mode <= MODE_COAST;
              right_duty <= '0;
              running    <= 1'b0;
              correction <= '0;
            end else begin
              if (l_zero) begin
                left_mode <= MODE_BRAKE;
                left_duty <= 8'hFF;
              end else begin
                left_mode <= item.l_neg ? MODE_REV : MODE_FWD;
                left_duty <= lm;
              end
              // right motor is mirrored
              if (r_zero) begin
                right_mode <= MODE_BRAKE;
                right_duty <= 8'hFF;
              end else begin
                right_mode <= item.r_neg ? MODE_FWD : MODE_REV;
                right_duty <= rm;
              end
              running    <= 1'b1;
              correction <= corr_eff;
            end
          end
          CMD_WATCH: begin
            if (running && item.stale) begin
              left_mode  <= MODE_COAST;
              left_duty  <= '0;
              right_mode <= MODE_COAST;
              right_duty <= '0;
              running    <= 1'b0;
            end
          end
          CMD_CLOSE: begin
            left_mode  <= MODE_COAST;
            left_duty  <= '0;
            right_mode <= MODE_COAST;
            right_duty <= '0;
            running    <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_close_stops: assert property (@(posedge clk) disable iff (rst)
    pop && item.cmd == CMD_CLOSE |=> !running && left_mode == MODE_COAST &&
                                     right_mode == MODE_COAST)
    else $error("link close did not stop motors");
  a_idle_coasts: assert property (@(posedge clk) disable iff (rst)
    !running |-> left_mode == MODE_COAST && right_mode == MODE_COAST)
    else $error("bridge driven while motors off");
  a_brake_full: assert property (@(posedge clk) disable iff (rst)
    (left_mode == MODE_BRAKE |-> left_duty == 8'hFF) and
    (right_mode == MODE_BRAKE |-> right_duty == 8'hFF))
    else $error("brake without full duty");

endmodule

@@ design/differential_drive_balance_controller.sv @@
// Two-motor differential drive controller. Each input transaction (stick report, control
// tick, watchdog check, link close) produces exactly one result transaction with the bridge
// modes and duties held after it, the running flag and the latest balance correction.
// Sustained throughput is one transaction per clock cycle while the output side is ready;
// each transaction passes through the four-stage front pipeline (stick mixing, reciprocal
// divides by 100 and 127, duty scaling and encoder correction), a four-entry queue and the
// result register in the back end. Configuration registers are written through
// cfg_we/cfg_index/cfg_data and take effect at once; write them only while no transaction
// is in flight.
module differential_drive_balance_controller import ddbc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [31:0]        now_time,
  input  logic [7:0]         stick_x,
  input  logic [7:0]         stick_y,
  input  logic signed [31:0] left_enc,
  input  logic signed [31:0] right_enc,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         left_mode,
  output logic [7:0]         left_duty,
  output logic [1:0]         right_mode,
  output logic [7:0]         right_duty,
  output logic               running,
  output logic signed [8:0]  correction
);

  ddbc_cfg_t  cfg;
  ddbc_item_t f_item, q_item;
  logic       f_valid, q_full, q_empty, q_pop, b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone          <= RST_DEAD_ZONE;
      cfg.steer_percent      <= RST_STEER_PCT;
      cfg.start_duty         <= RST_START_DUTY;
      cfg.max_duty           <= RST_MAX_DUTY;
      cfg.straight_tolerance <= RST_STRAIGHT;
      cfg.balance_gain       <= RST_GAIN;
      cfg.correction_limit   <= RST_CORR_LIM;
      cfg.timeout_ticks      <= RST_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEAD_ZONE:  cfg.dead_zone          <= cfg_data[6:0];
        REG_STEER_PCT:  cfg.steer_percent      <= cfg_data[6:0];
        REG_START_DUTY: cfg.start_duty         <= cfg_data[7:0];
        REG_MAX_DUTY:   cfg.max_duty           <= cfg_data[7:0];
        REG_STRAIGHT:   cfg.straight_tolerance <= cfg_data[7:0];
        REG_GAIN:       cfg.balance_gain       <= cfg_data[7:0];
        REG_CORR_LIM:   cfg.correction_limit   <= cfg_data[7:0];
        REG_TIMEOUT:    cfg.timeout_ticks      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ddbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .now_time   (now_time),
    .stick_x    (stick_x),
    .stick_y    (stick_y),
    .left_enc   (left_enc),
    .right_enc  (right_enc),
    .item_valid (f_valid),
    .item_ready (!q_full),
    .item       (f_item)
  );

  ddbc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (f_valid && !q_full),
    .din  (f_item),
    .pop  (q_pop),
    .dout (q_item),
    .full (q_full),
    .empty(q_empty)
  );

  assign q_pop = !q_empty && b_ready;

  ddbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(!q_empty),
    .item_ready(b_ready),
    .item      (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_mode (left_mode),
    .left_duty (left_duty),
    .right_mode(right_mode),
    .right_duty(right_duty),
    .running   (running),
    .correction(correction)
  );

endmodule

@@ tb/sv/differential_drive_balance_controller_tb.sv @@
module differential_drive_balance_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddbc_pkg::*;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int DRAIN_CYCLES    = 10;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int LONG_HOLD       = 60;

  typedef struct {
    logic [1:0]        lmode;
    logic [7:0]        lduty;
    logic [1:0]        rmode;
    logic [7:0]        rduty;
    logic              run;
    logic signed [8:0] corr;
  } bridge_out_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] tm;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] lc;
    logic [31:0] rc;
    bit          typed;
    bridge_out_t want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         command = CMD_REPORT;
  logic [31:0]        now_time = '0;
  logic [7:0]         stick_x = 8'd128;
  logic [7:0]         stick_y = 8'd128;
  logic signed [31:0] left_enc = '0;
  logic signed [31:0] right_enc = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         left_mode;
  logic [7:0]         left_duty;
  logic [1:0]         right_mode;
  logic [7:0]         right_duty;
  logic               running;
  logic signed [8:0]  correction;

  // stimulus pacing
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  cycles = 0;

  bridge_out_t expected_bridge[$];
  stim_row_t   directed_rows[$];

  // drive model state
  int          dz_cfg = RST_DEAD_ZONE;
  int          steer_cfg = RST_STEER_PCT;
  int          start_cfg = RST_START_DUTY;
  int          max_cfg = RST_MAX_DUTY;
  int          tol_cfg = RST_STRAIGHT;
  int          gain_cfg = RST_GAIN;
  int          lim_cfg = RST_CORR_LIM;
  logic [31:0] timeout_cfg = RST_TIMEOUT;
  int          tgt_l = 0;
  int          tgt_r = 0;
  logic [31:0] report_time = '0;
  logic [31:0] prev_l = '0;
  logic [31:0] prev_r = '0;
  bridge_out_t held = '{MODE_COAST, 8'd0, MODE_COAST, 8'd0, 1'b0, 9'sd0};

  differential_drive_balance_controller u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .now_time(now_time), .stick_x(stick_x), .stick_y(stick_y),
    .left_enc(left_enc), .right_enc(right_enc),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_mode(left_mode), .left_duty(left_duty),
    .right_mode(right_mode), .right_duty(right_duty),
    .running(running), .correction(correction)
  );

  always #5 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int axis_level(logic [7:0] a);
    int v;
    v = 128 - int'(a);
    if ((v < 0 ? -v : v) <= dz_cfg) return 0;
    return int'(clip(v, -127, 127));
  endfunction

  function automatic int duty_for(int t);
    int m;
    int d;
    if (t == 0) return 0;
    m = t < 0 ? -t : t;
    d = start_cfg + (m * (max_cfg - start_cfg)) / 127;
    d = int'(clip(d, 0, max_cfg));
    return t < 0 ? -d : d;
  endfunction

  function automatic void set_bridge(int pwm, output logic [1:0] mode,
                                     output logic [7:0] duty);
    int p;
    p = int'(clip(pwm, -255, 255));
    if (p == 0) begin
      mode = MODE_BRAKE;
      duty = 8'd255;
    end else if (p > 0) begin
      mode = MODE_FWD;
      duty = 8'(p);
    end else begin
      mode = MODE_REV;
      duty = 8'(-p);
    end
  endfunction

  function automatic void stop_drive();
    tgt_l = 0;
    tgt_r = 0;
    held.lmode = MODE_COAST;
    held.lduty = 8'd0;
    held.rmode = MODE_COAST;
    held.rduty = 8'd0;
    held.run = 1'b0;
  endfunction

  function automatic bridge_out_t advance_drive(logic [1:0] cmd, logic [31:0] tm,
                                                logic [7:0] x, logic [7:0] y,
                                                logic [31:0] lc, logic [31:0] rc);
    int          thr, st, l, r, lp, rp, lm, rm;
    longint      ald, ard, corr;
    logic [31:0] dl, dr;
    case (cmd)
      CMD_REPORT: begin
        thr = axis_level(y);
        st = (axis_level(x) * steer_cfg) / 100;
        l = int'(clip(thr + st, -127, 127));
        r = int'(clip(thr - st, -127, 127));
        report_time = tm;
        if (l == 0 && r == 0) begin
          stop_drive();
        end else begin
          tgt_l = l;
          tgt_r = r;
          held.run = 1'b1;
        end
      end
      CMD_TICK: begin
        dl = lc - prev_l;
        dr = rc - prev_r;
        prev_l = lc;
        prev_r = rc;
        ald = longint'($signed(dl));
        ard = longint'($signed(dr));
        if (ald < 0) ald = -ald;
        if (ard < 0) ard = -ard;
        if (tgt_l == 0 && tgt_r == 0) begin
          stop_drive();
          held.corr = 9'sd0;
        end else begin
          lp = duty_for(tgt_l);
          rp = duty_for(tgt_r);
          corr = 0;
          if (tgt_l != 0 && tgt_r != 0 && (tgt_l > 0) == (tgt_r > 0) &&
              ((tgt_l - tgt_r < 0) ? tgt_r - tgt_l : tgt_l - tgt_r) <= tol_cfg) begin
            corr = clip((ald - ard) * gain_cfg, -lim_cfg, lim_cfg);
            lm = int'(clip((lp < 0 ? -lp : lp) - corr, 0, 255));
            rm = int'(clip((rp < 0 ? -rp : rp) + corr, 0, 255));
            lp = (lp > 0) ? lm : (lp < 0) ? -lm : 0;
            rp = (rp > 0) ? rm : (rp < 0) ? -rm : 0;
          end
          set_bridge(lp, held.lmode, held.lduty);
          set_bridge(-rp, held.rmode, held.rduty);
          held.run = 1'b1;
          held.corr = 9'(corr);
        end
      end
      CMD_WATCH: begin
        if (held.run && (tm - report_time) > timeout_cfg) stop_drive();
      end
      default: stop_drive();
    endcase
    return held;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [31:0] tm, logic [7:0] x, logic [7:0] y,
                           logic [31:0] lc, logic [31:0] rc, bit typed, bridge_out_t want);
    bridge_out_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    now_time <= tm;
    stick_x <= x;
    stick_y <= y;
    left_enc <= lc;
    right_enc <= rc;
    do @(posedge clk); while (!in_ready);
    predicted = advance_drive(cmd, tm, x, y, lc, rc);
    expected_bridge.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_bridge.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(int dz, int st, int sd, int md, int tol, int gn, int lim,
                               logic [31:0] to);
    logic [31:0] vals [8];
    vals[REG_DEAD_ZONE]  = ($urandom() & 32'hFFFF_FF80) | 32'(dz);
    vals[REG_STEER_PCT]  = ($urandom() & 32'hFFFF_FF80) | 32'(st);
    vals[REG_START_DUTY] = ($urandom() & 32'hFFFF_FF00) | 32'(sd);
    vals[REG_MAX_DUTY]   = ($urandom() & 32'hFFFF_FF00) | 32'(md);
    vals[REG_STRAIGHT]   = ($urandom() & 32'hFFFF_FF00) | 32'(tol);
    vals[REG_GAIN]       = ($urandom() & 32'hFFFF_FF00) | 32'(gn);
    vals[REG_CORR_LIM]   = ($urandom() & 32'hFFFF_FF00) | 32'(lim);
    vals[REG_TIMEOUT]    = to;
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      case (3'(i))
        REG_DEAD_ZONE:  dz_cfg = int'(vals[i][6:0]);
        REG_STEER_PCT:  steer_cfg = int'(vals[i][6:0]);
        REG_START_DUTY: start_cfg = int'(vals[i][7:0]);
        REG_MAX_DUTY:   max_cfg = int'(vals[i][7:0]);
        REG_STRAIGHT:   tol_cfg = int'(vals[i][7:0]);
        REG_GAIN:       gain_cfg = int'(vals[i][7:0]);
        REG_CORR_LIM:   lim_cfg = int'(vals[i][7:0]);
        default:        timeout_cfg = vals[i];
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(logic [1:0] cmd, logic [31:0] tm, logic [7:0] x, logic [7:0] y,
                         logic [31:0] lc, logic [31:0] rc, bit typed,
                         logic [1:0] lm, int ld, logic [1:0] rm, int rd, bit run, int corr);
    stim_row_t row;
    row.cmd = cmd;
    row.tm = tm;
    row.x = x;
    row.y = y;
    row.lc = lc;
    row.rc = rc;
    row.typed = typed;
    row.want = '{lm, 8'(ld), rm, 8'(rd), run, 9'(corr)};
    directed_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    bridge_out_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bridge.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual mode %0d/%0d",
                   $time, left_mode, right_mode);
          mismatches++;
        end else begin
          w = expected_bridge.pop_front();
          check_field("left_mode", w.lmode, left_mode);
          check_field("left_duty", w.lduty, left_duty);
          check_field("right_mode", w.rmode, right_mode);
          check_field("right_duty", w.rduty, right_duty);
          check_field("running", w.run, running);
          check_field("correction", int'(w.corr), int'(correction));
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    bridge_out_t no_want;
    logic [1:0]  cmd_r;
    logic [31:0] tm_r, lc_r, rc_r;
    logic [7:0]  x_r, y_r;
    logic [31:0] clock_now, enc_l, enc_r;
    int          sel;

    no_want = '{MODE_COAST, 8'd0, MODE_COAST, 8'd0, 1'b0, 9'sd0};
    clock_now = $urandom();
    enc_l = $urandom();
    enc_r = enc_l;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_row(CMD_WATCH, 32'd5000, 8'd3, 8'd250, 32'd7, 32'd9, 1,
            MODE_COAST, 0, MODE_COAST, 0, 0, 0);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'd0, 32'd0, 1,
            MODE_COAST, 0, MODE_COAST, 0, 0, 0);
    add_row(CMD_REPORT, 32'd100, 8'd128, 8'd128, 32'd0, 32'd0, 1,
            MODE_COAST, 0, MODE_COAST, 0, 0, 0);
    add_row(CMD_REPORT, 32'd200, 8'd128, 8'd0, 32'd0, 32'd0, 1,
            MODE_COAST, 0, MODE_COAST, 0, 1, 0);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'd10, 32'd10, 1,
            MODE_FWD, 210, MODE_REV, 210, 1, 0);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'd40, 32'd10, 1,
            MODE_FWD, 190, MODE_REV, 230, 1, 20);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'd40, 32'd50, 1,
            MODE_FWD, 230, MODE_REV, 190, 1, -20);
    // watchdog boundary: equal to timeout keeps running, one past stops
    add_row(CMD_WATCH, 32'd1700, 8'd0, 8'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_WATCH, 32'd1701, 8'd0, 8'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_CLOSE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
            0, 0, 0, 0, 0, 0);
    add_row(CMD_REPORT, 32'hFFFF_FF00, 8'd128, 8'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    // encoder wrap, including a delta of the most negative count
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'h8000_0000, 32'd50, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'd0, 32'd50, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_WATCH, 32'h0000_0400, 8'd0, 8'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_REPORT, 32'd300, 8'd255, 8'd255, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'hFFFF_FF9C, 0,
            0, 0, 0, 0, 0, 0);
    add_row(CMD_REPORT, 32'd400, 8'd0, 8'd128, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'd5, 32'hFFFF_FFFB, 0, 0, 0, 0, 0, 0, 0);
    // one target zero while running: that side brakes
    add_row(CMD_REPORT, 32'd500, 8'd228, 8'd83, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'd9, 32'd3, 0, 0, 0, 0, 0, 0, 0);
    // dead zone edges
    add_row(CMD_REPORT, 32'd600, 8'd128, 8'd110, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_REPORT, 32'd700, 8'd128, 8'd109, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_TICK, 32'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_REPORT, 32'd800, 8'd147, 8'd128, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_CLOSE, 32'd0, 8'd0, 8'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0, 0, 0);

    foreach (directed_rows[i])
      send_item(directed_rows[i].cmd, directed_rows[i].tm, directed_rows[i].x,
                directed_rows[i].y, directed_rows[i].lc, directed_rows[i].rc,
                directed_rows[i].typed, directed_rows[i].want);
    wait_drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: ;
        1: load_settings(0, 100, 0, 255, 254, 255, 255, 32'd0);
        3: load_settings(5, 50, 0, 0, 20, 3, 255, 32'd300);
        5: load_settings(127, 127, 255, 0, 0, 0, 0, 32'hFFFF_FFFF);
        default:
          load_settings($urandom_range(0, 60), $urandom_range(0, 127), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 254),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 3000));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      if (p == 0) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        tm_r = $urandom();
        x_r = 8'($urandom());
        y_r = 8'($urandom());
        lc_r = $urandom();
        rc_r = $urandom();
        if (sel < 25) begin
          cmd_r = CMD_REPORT;
          clock_now = clock_now + $urandom_range(0, 400);
          tm_r = clock_now;
          if ($urandom_range(0, 1) == 1) x_r = 8'($urandom_range(108, 148));
          if ($urandom_range(0, 3) == 0) y_r = 8'($urandom_range(100, 156));
        end else if (sel < 70) begin
          cmd_r = CMD_TICK;
          if ($urandom_range(0, 19) != 0) begin
            enc_l = enc_l + $urandom_range(0, 120) - 32'd60;
            enc_r = enc_r + $urandom_range(0, 120) - 32'd60;
            lc_r = enc_l;
            rc_r = enc_r;
          end else begin
            enc_l = lc_r;
            enc_r = rc_r;
          end
        end else if (sel < 85) begin
          cmd_r = CMD_WATCH;
          clock_now = clock_now + $urandom_range(0, 2500);
          if ($urandom_range(0, 19) != 0) tm_r = clock_now;
        end else if (sel < 90) begin
          cmd_r = CMD_CLOSE;
        end else begin
          cmd_r = 2'($urandom());
        end
        send_item(cmd_r, tm_r, x_r, y_r, lc_r, rc_r, 1'b0, no_want);
      end
      wait_drain();
    end

    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
